/* src/sobel_gradient_energy_defines.svh */
// assertion macros for the sobel gradient energy checker
`ifndef SOBEL_GRADIENT_ENERGY_DEFINES_SVH
`define SOBEL_GRADIENT_ENERGY_DEFINES_SVH

// property checked on every clock edge outside reset
`define SGE_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked in the cycle after a stalled result beat
`define SGE_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (o_res_valid && !i_res_ready) |=> cond) else $error(msg);

`endif

/* src/sge_pkg.sv */
`default_nettype none

package sge_pkg;

    // frame geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 8;
    localparam int ENERGY_W  = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // reset values and limits of the config registers
    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);
    localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(3);
    localparam logic [CFG_W-1:0] MAX_WIDTH_CFG = CFG_W'(MAX_WIDTH);

    localparam logic [ENERGY_W-1:0] BORDER_ENERGY = ENERGY_W'(255);

    // result slots released by one pixel, in emission order
    localparam int N_EMIT      = 4;
    localparam int EMIT_MAIN   = 0;
    localparam int EMIT_RIGHT  = 1;
    localparam int EMIT_BOTTOM = 2;
    localparam int EMIT_CORNER = 3;

    // one pixel's worth of pending results
    typedef struct packed {
        logic [N_EMIT-1:0]   mask;
        logic [ENERGY_W-1:0] energy;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
    } t_emit;

endpackage

`default_nettype wire

/* src/sobel_gradient_energy.sv */
// Sobel L1 gradient energy over a grey frame streamed in raster order.
// Pixel channel: i_pixel_valid / o_pixel_ready carry one 8-bit pixel per beat.
// Result channel: o_res_valid / i_res_ready carry one energy per beat with its
// row and column; o_last_of_run marks the final result a pixel releases and
// o_end_of_frame the frame's last result. Pixel (r,c) releases the energy of
// (r-1,c-1) plus, at the last column and on the last row, border values (255).
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index 0 = width, 1 = height;
// o_cfg_ready is always high; a write to index 0 or 1 restarts the frame at
// row 0, col 0. A result goes from the pixel register via the pending results
// register to the output register. Throughput: one pixel per cycle while each
// pixel releases at most one result and the receiver is ready; a pixel with
// more (2 at each row end and on the last row, 4 at the frame's last pixel)
// holds the pixel register, as the output register sends one result per cycle.
// A stalled receiver holds the output register; a pixel register and a result
// queue of one pixel keep the pixel side open until both are full.
// Reset: counters at the frame start, width 640, height 480, window zero; the
// line stores are not cleared, their stale entries only feed border results.
`default_nettype none

module sobel_gradient_energy (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_pixel_valid,
    output logic                                o_pixel_ready,
    input  wire logic [sge_pkg::PIX_W-1:0]      i_pixel,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output logic      [sge_pkg::ENERGY_W-1:0]   o_energy,
    output logic      [sge_pkg::ROW_W-1:0]      o_row,
    output logic      [sge_pkg::COL_W-1:0]      o_column,
    output logic                                o_last_of_run,
    output logic                                o_end_of_frame,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sge_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sge_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [sge_pkg::CFG_W-1:0] r_image_width, r_image_height;
    logic [sge_pkg::CFG_W-1:0] w_width, w_height;
    logic [sge_pkg::COL_W-1:0] w_col_last;
    logic [sge_pkg::ROW_W-1:0] w_row_last;

    logic [sge_pkg::ROW_W-1:0] r_row, w_row_cur;
    logic [sge_pkg::COL_W-1:0] r_col, w_col_cur;

    logic [sge_pkg::PIX_W-1:0] r_mem_upper  [sge_pkg::MAX_WIDTH];
    logic [sge_pkg::PIX_W-1:0] r_mem_middle [sge_pkg::MAX_WIDTH];
    logic [sge_pkg::PIX_W-1:0] r_rd_upper, r_rd_middle;

    logic                        r_s1_valid;
    logic [sge_pkg::PIX_W-1:0]   r_s1_pixel;
    logic [sge_pkg::ROW_W-1:0]   r_s1_row;
    logic [sge_pkg::COL_W-1:0]   r_s1_col;
    logic [sge_pkg::N_EMIT-1:0]  r_s1_mask, w_mask;
    logic                        r_s1_interior, w_interior;

    logic                         w_accept, w_cfg_wr, w_s1_adv, w_em_can_load;
    logic [sge_pkg::ENERGY_W-1:0] w_sobel;
    sge_pkg::t_emit               w_item;

    // effective frame size
    always_comb begin
        w_width = r_image_width;
        if (r_image_width < sge_pkg::MIN_SIZE) begin
            w_width = sge_pkg::MIN_SIZE;
        end else if (r_image_width > sge_pkg::MAX_WIDTH_CFG) begin
            w_width = sge_pkg::MAX_WIDTH_CFG;
        end
        w_height = (r_image_height < sge_pkg::MIN_SIZE) ? sge_pkg::MIN_SIZE : r_image_height;
    end

    assign w_col_last = sge_pkg::COL_W'(w_width - sge_pkg::CFG_W'(1));
    assign w_row_last = w_height - sge_pkg::ROW_W'(1);

    // position of the incoming pixel
    assign w_col_cur = ({1'b0, r_col} >= w_width) ? '0 : r_col;
    assign w_row_cur = (r_row >= w_height) ? '0 : r_row;

    // results this pixel releases
    always_comb begin
        w_mask = '0;
        w_mask[sge_pkg::EMIT_MAIN]   = (w_row_cur != '0) && (w_col_cur != '0);
        w_mask[sge_pkg::EMIT_RIGHT]  = (w_row_cur != '0) && (w_col_cur == w_col_last);
        w_mask[sge_pkg::EMIT_BOTTOM] = (w_row_cur == w_row_last) && (w_col_cur != '0);
        w_mask[sge_pkg::EMIT_CORNER] = (w_row_cur == w_row_last) && (w_col_cur == w_col_last);
        w_interior = (w_row_cur >= sge_pkg::ROW_W'(2)) && (w_col_cur >= sge_pkg::COL_W'(2));
    end

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign w_s1_adv      = r_s1_valid && w_em_can_load;
    assign o_pixel_ready = !r_s1_valid || w_s1_adv;
    assign w_accept      = i_pixel_valid && o_pixel_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sge_pkg::RESET_WIDTH;
            r_image_height <= sge_pkg::RESET_HEIGHT;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                sge_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                sge_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // raster position counters, restarted by a width or height register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_cfg_wr && ((i_cfg_index == sge_pkg::REG_IMAGE_WIDTH) ||
                                  (i_cfg_index == sge_pkg::REG_IMAGE_HEIGHT))) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (w_col_cur == w_col_last) begin
                r_col <= '0;
                r_row <= (w_row_cur == w_row_last) ? '0 : (w_row_cur + sge_pkg::ROW_W'(1));
            end else begin
                r_col <= w_col_cur + sge_pkg::COL_W'(1);
                r_row <= w_row_cur;
            end
        end
    end

    // middle line store: read old value and write the new pixel on the beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_middle             <= r_mem_middle[w_col_cur];
            r_mem_middle[w_col_cur] <= i_pixel;
        end
    end

    // upper line store: read on the beat, take the old middle value on w_s1_adv
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_upper <= r_mem_upper[w_col_cur];
        end
        if (w_s1_adv) begin
            r_mem_upper[r_s1_col] <= r_rd_middle;
        end
    end

    // pixel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pixel    <= i_pixel;
            r_s1_row      <= w_row_cur;
            r_s1_col      <= w_col_cur;
            r_s1_mask     <= w_mask;
            r_s1_interior <= w_interior;
        end
    end

    sge_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_s1_adv),
        .i_top    (r_rd_upper),
        .i_mid    (r_rd_middle),
        .i_bot    (r_s1_pixel),
        .o_energy (w_sobel)
    );

    // results of the pixel in the pixel register
    always_comb begin
        w_item.mask   = r_s1_mask;
        w_item.energy = r_s1_interior ? w_sobel : sge_pkg::BORDER_ENERGY;
        w_item.row    = r_s1_row;
        w_item.col    = r_s1_col;
    end

    sge_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_s1_adv),
        .i_item         (w_item),
        .o_can_load     (w_em_can_load),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_energy       (o_energy),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

`default_nettype wire

/* src/sge_window.sv */
`default_nettype none

module sge_window (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire logic [sge_pkg::PIX_W-1:0]    i_top,
    input  wire logic [sge_pkg::PIX_W-1:0]    i_mid,
    input  wire logic [sge_pkg::PIX_W-1:0]    i_bot,
    output logic      [sge_pkg::ENERGY_W-1:0] o_energy
);

    logic [sge_pkg::PIX_W-1:0] r_win [9];
    logic [sge_pkg::PIX_W-1:0] n_win [9];
    logic [9:0] w_left, w_right, w_upper, w_lower;
    logic [9:0] w_gx, w_gy;

    // shift the 3x3 window left and take in the new column
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = i_bot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

    // sobel sums on the window that includes the new column
    always_comb begin
        w_left  = {2'b00, n_win[0]} + {1'b0, n_win[3], 1'b0} + {2'b00, n_win[6]};
        w_right = {2'b00, n_win[2]} + {1'b0, n_win[5], 1'b0} + {2'b00, n_win[8]};
        w_upper = {2'b00, n_win[0]} + {1'b0, n_win[1], 1'b0} + {2'b00, n_win[2]};
        w_lower = {2'b00, n_win[6]} + {1'b0, n_win[7], 1'b0} + {2'b00, n_win[8]};
        w_gx    = (w_left >= w_right) ? (w_left - w_right) : (w_right - w_left);
        w_gy    = (w_upper >= w_lower) ? (w_upper - w_lower) : (w_lower - w_upper);
    end

    assign o_energy = {1'b0, w_gx} + {1'b0, w_gy};

endmodule

`default_nettype wire

/* src/sge_emitter.sv */
`default_nettype none

module sge_emitter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire sge_pkg::t_emit               i_item,
    output logic                              o_can_load,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output logic      [sge_pkg::ENERGY_W-1:0] o_energy,
    output logic      [sge_pkg::ROW_W-1:0]    o_row,
    output logic      [sge_pkg::COL_W-1:0]    o_column,
    output logic                              o_last_of_run,
    output logic                              o_end_of_frame
);

    sge_pkg::t_emit r_pend;
    logic [sge_pkg::N_EMIT-1:0]   w_rest;
    logic                         w_pop;
    logic [sge_pkg::ENERGY_W-1:0] w_energy;
    logic [sge_pkg::ROW_W-1:0]    w_row;
    logic [sge_pkg::COL_W-1:0]    w_col;
    logic                         w_eof;

    // pop the lowest pending slot whenever the output register frees up
    assign w_rest     = r_pend.mask & (r_pend.mask - sge_pkg::N_EMIT'(1));
    assign w_pop      = (|r_pend.mask) && (!o_res_valid || i_res_ready);
    assign o_can_load = (r_pend.mask == '0) || (w_pop && (w_rest == '0));

    // fields of the slot being popped
    always_comb begin
        w_energy = sge_pkg::BORDER_ENERGY;
        w_row    = r_pend.row;
        w_col    = r_pend.col;
        w_eof    = 1'b0;
        priority if (r_pend.mask[sge_pkg::EMIT_MAIN]) begin
            w_energy = r_pend.energy;
            w_row    = r_pend.row - sge_pkg::ROW_W'(1);
            w_col    = r_pend.col - sge_pkg::COL_W'(1);
        end else if (r_pend.mask[sge_pkg::EMIT_RIGHT]) begin
            w_row    = r_pend.row - sge_pkg::ROW_W'(1);
        end else if (r_pend.mask[sge_pkg::EMIT_BOTTOM]) begin
            w_col    = r_pend.col - sge_pkg::COL_W'(1);
        end else begin
            w_eof    = 1'b1;
        end
    end

    // pending slots of the current pixel
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pend.energy <= i_item.energy;
            r_pend.row    <= i_item.row;
            r_pend.col    <= i_item.col;
        end
        if (!i_rst_n) begin
            r_pend.mask <= '0;
        end else if (i_load) begin
            r_pend.mask <= i_item.mask;
        end else if (w_pop) begin
            r_pend.mask <= w_rest;
        end
    end

    // output register, one result beat per cycle unless stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (w_pop) begin
            o_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            o_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            o_energy       <= w_energy;
            o_row          <= w_row;
            o_column       <= w_col;
            o_last_of_run  <= (w_rest == '0);
            o_end_of_frame <= w_eof;
        end
    end

endmodule

`default_nettype wire

/* src/sge_checker.sv */
`default_nettype none
`include "sobel_gradient_energy_defines.svh"

module sge_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_res_valid,
    input wire logic                         i_res_ready,
    input wire logic [sge_pkg::ENERGY_W-1:0] o_energy,
    input wire logic [sge_pkg::ROW_W-1:0]    o_row,
    input wire logic [sge_pkg::COL_W-1:0]    o_column,
    input wire logic                         o_last_of_run,
    input wire logic                         o_end_of_frame
);

    // a stalled result beat stays offered
    `SGE_ASSERT_HOLD(a_res_valid_hold, o_res_valid, "result valid dropped while stalled")

    // a stalled result beat keeps its payload
    `SGE_ASSERT_HOLD(a_res_payload_hold, $stable(o_energy) && $stable(o_row) && $stable(o_column) && $stable(o_last_of_run) && $stable(o_end_of_frame), "result payload changed while stalled")

    // frame end closes its pixel's run and is a border value
    `SGE_ASSERT_CLK(a_eof_is_last_border, (o_res_valid && o_end_of_frame) |-> (o_last_of_run && (o_energy == sge_pkg::BORDER_ENERGY)), "end of frame on a non-final or non-border result")

    // L1 magnitude never exceeds eight full-scale steps
    `SGE_ASSERT_CLK(a_energy_range, o_res_valid |-> (o_energy <= sge_pkg::ENERGY_W'(2040)), "energy out of range")

endmodule

bind sobel_gradient_energy sge_checker u_sge_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_energy       (o_energy),
    .o_row          (o_row),
    .o_column       (o_column),
    .o_last_of_run  (o_last_of_run),
    .o_end_of_frame (o_end_of_frame)
);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 100;

    // one result beat as the block should send it
    typedef struct packed {
        logic [sge_pkg::ENERGY_W-1:0] energy;
        logic [sge_pkg::ROW_W-1:0]    row;
        logic [sge_pkg::COL_W-1:0]    column;
        logic                         last_of_run;
        logic                         end_of_frame;
    } t_energy_beat;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_pixel_valid  = 1'b0;
    logic [sge_pkg::PIX_W-1:0]     i_pixel        = '0;
    logic                          i_res_ready    = 1'b0;
    logic                          i_cfg_valid    = 1'b0;
    logic [sge_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [sge_pkg::CFG_W-1:0]     i_cfg_data     = '0;
    logic                          o_pixel_ready;
    logic                          o_res_valid;
    logic [sge_pkg::ENERGY_W-1:0]  o_energy;
    logic [sge_pkg::ROW_W-1:0]     o_row;
    logic [sge_pkg::COL_W-1:0]     o_column;
    logic                          o_last_of_run;
    logic                          o_end_of_frame;
    logic                          o_cfg_ready;

    // energies still owed by the block, oldest first
    t_energy_beat energy_q[$];
    int unsigned  n_errors = 0;

    // shadow of the block state
    logic [sge_pkg::CFG_W-1:0] cfg_width  = sge_pkg::RESET_WIDTH;
    logic [sge_pkg::CFG_W-1:0] cfg_height = sge_pkg::RESET_HEIGHT;
    bit   [sge_pkg::PIX_W-1:0] upper_line[sge_pkg::MAX_WIDTH];
    bit   [sge_pkg::PIX_W-1:0] middle_line[sge_pkg::MAX_WIDTH];
    bit   [sge_pkg::PIX_W-1:0] nbhd[9];
    int unsigned      cur_row = 0;
    int unsigned      cur_col = 0;

    // stimulus knobs
    bit          px_idle_en  = 1'b0;
    bit          res_idle_en = 1'b0;
    int unsigned hold_req    = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;
    int unsigned stall_left  = 0;
    int unsigned stuck_cycles = 0;

    sobel_gradient_energy u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_energy       (o_energy),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_energy_beat make_beat(input int unsigned energy, input int unsigned r,
                                               input int unsigned c, input bit eof);
        t_energy_beat b;
        b.energy       = sge_pkg::ENERGY_W'(energy);
        b.row          = sge_pkg::ROW_W'(r);
        b.column       = sge_pkg::COL_W'(c);
        b.last_of_run  = 1'b0;
        b.end_of_frame = eof;
        make_beat = b;
    endfunction

    // energies released by one accepted pixel
    function automatic void predict_energy(input logic [sge_pkg::PIX_W-1:0] pix);
        int unsigned  w, h, r, c, n;
        int           gx, gy;
        int           px[9];
        t_energy_beat beats[sge_pkg::N_EMIT];
        w = cfg_width;
        if (w < sge_pkg::MIN_SIZE) w = sge_pkg::MIN_SIZE;
        if (w > sge_pkg::MAX_WIDTH) w = sge_pkg::MAX_WIDTH;
        h = cfg_height;
        if (h < sge_pkg::MIN_SIZE) h = sge_pkg::MIN_SIZE;
        r = cur_row;
        c = cur_col;
        n = 0;
        if (c >= w) c = 0;
        if (r >= h) r = 0;

        // slide the window left, new right column from the line stores
        for (int k = 0; k < 3; k++) begin
            nbhd[3*k]     = nbhd[3*k+1];
            nbhd[3*k + 1] = nbhd[3*k+2];
        end
        nbhd[2] = upper_line[c];
        nbhd[5] = middle_line[c];
        nbhd[8] = pix;
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;

        // energy of the pixel up and left, border if it sits on the edge
        if (r >= 1 && c >= 1) begin
            if (r >= 2 && c >= 2) begin
                for (int k = 0; k < 9; k++) px[k] = nbhd[k];
                gx = (px[0] + 2*px[3] + px[6]) - (px[2] + 2*px[5] + px[8]);
                gy = (px[0] + 2*px[1] + px[2]) - (px[6] + 2*px[7] + px[8]);
                if (gx < 0) gx = -gx;
                if (gy < 0) gy = -gy;
                beats[n] = make_beat(gx + gy, r - 1, c - 1, 1'b0);
            end else begin
                beats[n] = make_beat(sge_pkg::BORDER_ENERGY, r - 1, c - 1, 1'b0);
            end
            n++;
        end
        // right border of the row above
        if (r >= 1 && c == w - 1) begin
            beats[n] = make_beat(sge_pkg::BORDER_ENERGY, r - 1, w - 1, 1'b0);
            n++;
        end
        // bottom border interleaved on the last row
        if (r == h - 1 && c >= 1) begin
            beats[n] = make_beat(sge_pkg::BORDER_ENERGY, h - 1, c - 1, 1'b0);
            n++;
        end
        if (r == h - 1 && c == w - 1) begin
            beats[n] = make_beat(sge_pkg::BORDER_ENERGY, h - 1, w - 1, 1'b1);
            n++;
        end
        if (n > 0) beats[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++) energy_q.push_back(beats[k]);

        // advance raster position
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    function automatic void check_field(input string fname, input logic [11:0] exp_v,
                                        input logic [11:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // track config writes and pixel beats, check result beats
    always @(posedge i_clk) begin
        t_energy_beat exp_b;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == sge_pkg::REG_IMAGE_WIDTH) begin
                    cfg_width = i_cfg_data;
                    cur_row   = 0;
                    cur_col   = 0;
                end else if (i_cfg_index == sge_pkg::REG_IMAGE_HEIGHT) begin
                    cfg_height = i_cfg_data;
                    cur_row    = 0;
                    cur_col    = 0;
                end
            end
            if (i_pixel_valid && o_pixel_ready) predict_energy(i_pixel);
            if (o_res_valid && i_res_ready) begin
                if (energy_q.size() == 0) begin
                    $display("%0t: result with none expected: energy %0d row %0d column %0d",
                             $time, o_energy, o_row, o_column);
                    n_errors++;
                end else begin
                    exp_b = energy_q.pop_front();
                    check_field("energy", exp_b.energy, o_energy);
                    check_field("row", exp_b.row, o_row);
                    check_field("column", exp_b.column, o_column);
                    check_field("last_of_run", exp_b.last_of_run, o_last_of_run);
                    check_field("end_of_frame", exp_b.end_of_frame, o_end_of_frame);
                end
            end
        end
    end

    // result side: long hold on request, else random stall bursts
    always @(posedge i_clk) begin
        if (hold_served != hold_req) begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_res_ready <= 1'b0;
        end else if (res_idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_pixel_valid && o_pixel_ready) || (o_res_valid && i_res_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [sge_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0:       rand_pixel = '0;
            1:       rand_pixel = '1;
            default: rand_pixel = sge_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel beat, with an optional gap in front
    task automatic send_pixel(input logic [sge_pkg::PIX_W-1:0] pix);
        int unsigned gap;
        if (px_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_pixel_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel       <= pix;
        do @(posedge i_clk); while (!o_pixel_ready);
    endtask

    // stop sending and wait until every owed energy has come back
    task automatic drain_results(input int settle);
        i_pixel_valid <= 1'b0;
        while (energy_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sge_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sge_pkg::CFG_W-1:0] val);
        drain_results(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int unsigned count);
        for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    endtask

    // default 640x480 geometry straight out of reset, first row releases nothing
    task automatic test_reset_geometry();
        send_random(16);
    endtask

    // 3x3 frames with a diagonal step, both polarities, centre energy 1530
    task automatic test_step_edges();
        logic [sge_pkg::PIX_W-1:0] step_img[9] = '{8'hFF, 8'hFF, 8'h00,
                                                   8'hFF, 8'h00, 8'h00,
                                                   8'h00, 8'h00, 8'h00};
        px_idle_en  = 1'b1;
        res_idle_en = 1'b1;
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(3));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(3));
        for (int i = 0; i < 9; i++) send_pixel(step_img[i]);
        for (int i = 0; i < 9; i++) send_pixel(~step_img[8 - i]);
    endtask

    // sizes below the minimum act as 3
    task automatic test_size_clamp();
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(0));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(0));
        send_random(9);
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(2));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(1));
        send_random(13);
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(1));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(2));
        send_random(9);
    endtask

    // width above the line store size, start of the first row
    task automatic test_wide_rows();
        px_idle_en  = 1'b0;
        res_idle_en = 1'b1;
        write_reg(sge_pkg::REG_IMAGE_WIDTH, '1);
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(3));
        send_random(8);
    endtask

    // tallest frame: no bottom border within the first rows
    task automatic test_tall_frame();
        px_idle_en = 1'b1;
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(3));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, '1);
        send_random(11);
    endtask

    // a write in the middle of a frame starts a new one
    task automatic test_restart();
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(5));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(4));
        send_random(13);
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(4));
        send_random(20);
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(7));
        send_random(28);
    endtask

    // receiver holds off while pixels keep coming
    task automatic test_backpressure();
        px_idle_en  = 1'b0;
        res_idle_en = 1'b0;
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(5));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(4));
        hold_req++;
        send_random(40);
        drain_results(SETTLE_CYCLES);
    endtask

    // small random frames, some cut short, some with a pause mid-frame
    task automatic test_random_frames();
        int unsigned w_wr, h_wr, w, h, total, pause_at, sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w_wr = $urandom_range(0, 12);
            h_wr = $urandom_range(0, 6);
            w = (w_wr < 3) ? 3 : w_wr;
            h = (h_wr < 3) ? 3 : h_wr;
            write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(w_wr));
            write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(h_wr));
            px_idle_en  = $urandom_range(0, 1);
            res_idle_en = $urandom_range(0, 1);
            total = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total - 1);
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : 0;
            for (int i = 0; i < total; i++) begin
                if (i != 0 && i == pause_at) drain_results(SETTLE_CYCLES);
                send_pixel(rand_pixel());
                sent++;
            end
        end
    endtask

    // back to back with no idling on either side
    task automatic test_full_rate();
        write_reg(sge_pkg::REG_IMAGE_WIDTH, sge_pkg::CFG_W'(8));
        write_reg(sge_pkg::REG_IMAGE_HEIGHT, sge_pkg::CFG_W'(5));
        px_idle_en  = 1'b0;
        res_idle_en = 1'b0;
        send_random(40);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_step_edges();
        test_size_clamp();
        test_wide_rows();
        test_tall_frame();
        test_restart();
        test_backpressure();
        test_random_frames();
        test_full_rate();
        drain_results(4 * SETTLE_CYCLES);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
